// ----- sv/sgpb_pkg.sv -----
// ----------------------------------------------------------------------------
// sgpb_pkg
// Shared types and constants for the subpixel glyph pixel blend pipeline.
// ----------------------------------------------------------------------------
package sgpb_pkg;

  // field widths
  localparam int LX_W        = 12;  // local_x field on the stream
  localparam int X_BITS      = 12;  // bits of local_x that are used
  localparam int GLYPH_WIDTH = 8;   // columns present in a glyph row
  localparam int ROW_W       = 8;   // glyph row field width
  localparam int CH_W        = 8;   // colour channel width
  localparam int INV_W       = 16;  // inverse scale, Q4.12
  localparam int INV_FRAC    = 12;
  localparam int FRAC_W      = 8;   // subpixel offsets, Q0.8
  localparam int PROD_W      = X_BITS + INV_W;
  localparam int IDX_W       = PROD_W - INV_FRAC;
  localparam int WGT_W       = 2 * FRAC_W + 1;  // Q0.16 weight, up to 1.0
  localparam int COV_W       = WGT_W;
  localparam int MIX_W       = CH_W + COV_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = INV_W;

  // coverage thresholds in Q0.16
  // skip when 100*c <= 65536, i.e. c <= 655
  // text when 20*c > 19*65536, i.e. c >= 62260
  localparam logic [COV_W-1:0] ONE_Q16  = COV_W'(65536);
  localparam logic [COV_W-1:0] SKIP_MAX = COV_W'(655);
  localparam logic [COV_W-1:0] TEXT_MIN = COV_W'(62260);

  typedef enum logic [1:0] {
    ACT_LEAVE = 2'd0,
    ACT_TEXT  = 2'd1,
    ACT_BLEND = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HSCALE      = 3'd0,
    REG_FRAC_X      = 3'd1,
    REG_FRAC_Y      = 3'd2,
    REG_TEXT_RED    = 3'd3,
    REG_TEXT_GREEN  = 3'd4,
    REG_TEXT_BLUE   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [INV_W-1:0]  hscale;
    logic [FRAC_W-1:0] frac_x;
    logic [FRAC_W-1:0] frac_y;
    rgb_t              text;
  } cfg_t;

  // after index stage
  typedef struct packed {
    logic [IDX_W-1:0] sx;
    logic [IDX_W-1:0] sxs;
    logic             sxs_ok;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] prev;
    rgb_t             bg;
  } samp_t;

  // after coverage stage
  typedef struct packed {
    logic [COV_W-1:0] cov;
    rgb_t             bg;
  } cov_t;

endpackage

// ----- sv/sgpb_index.sv -----
// ----------------------------------------------------------------------------
// sgpb_index
// Stage one: scales the column to the two horizontal glyph sample indices.
// ----------------------------------------------------------------------------
module sgpb_index
  import sgpb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [INV_W-1:0]  hscale,
  input  logic [X_BITS-1:0] x,
  input  logic [ROW_W-1:0]  row,
  input  logic [ROW_W-1:0]  prev,
  input  rgb_t              bg,
  output samp_t             samp
);

  logic [X_BITS-1:0] x_m1;
  logic [PROD_W-1:0] prod_cur;
  logic [PROD_W-1:0] prod_left;

  always_comb begin
    x_m1      = x - X_BITS'(1);
    prod_cur  = PROD_W'(x) * PROD_W'(hscale);
    prod_left = PROD_W'(x_m1) * PROD_W'(hscale);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      samp.sx   <= prod_cur[PROD_W-1:INV_FRAC];
      samp.row  <= row;
      samp.prev <= prev;
      samp.bg   <= bg;
      if (x == '0) begin
        // -inv truncates towards zero: index 0 only while the inverse scale is below one
        samp.sxs    <= '0;
        samp.sxs_ok <= (hscale[INV_W-1:INV_FRAC] == '0);
      end else begin
        samp.sxs    <= prod_left[PROD_W-1:INV_FRAC];
        samp.sxs_ok <= 1'b1;
      end
    end
  end

endmodule

// ----- sv/sgpb_coverage.sv -----
// ----------------------------------------------------------------------------
// sgpb_coverage
// Stage two: picks the four glyph bits and sums their bilinear weights.
// ----------------------------------------------------------------------------
module sgpb_coverage
  import sgpb_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  cfg_t  cfg,
  input  samp_t samp,
  output cov_t  cov
);

  logic [FRAC_W:0]    ifx, ify, fx, fy;
  logic [WGT_W:0]     p_cc, p_cl, p_pc, p_pl;
  logic [WGT_W-1:0]   w_cc, w_cl, w_pc, w_pl;   // row/prev x current/left column
  logic               b_cc, b_cl, b_pc, b_pl;
  logic [COV_W+1:0]   sum;

  function automatic logic bit_at(input logic [ROW_W-1:0] r, input logic ok,
                                  input logic [IDX_W-1:0] idx);
    logic b;
    b = 1'b0;
    for (int i = 0; i < ROW_W; i++) begin
      if (ok && (i < GLYPH_WIDTH) && (idx == IDX_W'(i))) b = r[i];
    end
    return b;
  endfunction

  always_comb begin
    fx   = {1'b0, cfg.frac_x};
    fy   = {1'b0, cfg.frac_y};
    ifx  = (FRAC_W+1)'(1 << FRAC_W) - fx;
    ify  = (FRAC_W+1)'(1 << FRAC_W) - fy;
    p_cc = (WGT_W+1)'(ifx) * (WGT_W+1)'(ify);
    p_cl = (WGT_W+1)'(fx) * (WGT_W+1)'(ify);
    p_pc = (WGT_W+1)'(ifx) * (WGT_W+1)'(fy);
    p_pl = (WGT_W+1)'(fx) * (WGT_W+1)'(fy);
  end

  // weights follow the config registers in the next cycle, through a register with no enable
  always_ff @(posedge clk) begin
    w_cc <= p_cc[WGT_W-1:0];
    w_cl <= p_cl[WGT_W-1:0];
    w_pc <= p_pc[WGT_W-1:0];
    w_pl <= p_pl[WGT_W-1:0];
  end

  always_comb begin
    b_cc = bit_at(samp.row,  1'b1,        samp.sx);
    b_cl = bit_at(samp.row,  samp.sxs_ok, samp.sxs);
    b_pc = bit_at(samp.prev, 1'b1,        samp.sx);
    b_pl = bit_at(samp.prev, samp.sxs_ok, samp.sxs);
    sum  = (b_cc ? (COV_W+2)'(w_cc) : '0) + (b_cl ? (COV_W+2)'(w_cl) : '0)
         + (b_pc ? (COV_W+2)'(w_pc) : '0) + (b_pl ? (COV_W+2)'(w_pl) : '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov.cov <= sum[COV_W-1:0];
      cov.bg  <= samp.bg;
    end
  end

endmodule

// ----- sv/sgpb_mix.sv -----
// ----------------------------------------------------------------------------
// sgpb_mix
// Stages three and four: classifies coverage and blends background to text.
// ----------------------------------------------------------------------------
module sgpb_mix
  import sgpb_pkg::*;
(
  input  logic    clk,
  input  logic    en_mul,
  input  logic    en_out,
  input  rgb_t    text,
  input  cov_t    cov,
  output action_t action,
  output rgb_t    color
);

  logic [COV_W-1:0] inv_cov;
  action_t          act_mul;
  logic [MIX_W-1:0] bg_r, bg_g, bg_b, fg_r, fg_g, fg_b;
  logic [MIX_W:0]   sum_r, sum_g, sum_b;
  rgb_t             blend;

  assign inv_cov = ONE_Q16 - cov.cov;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      if (cov.cov <= SKIP_MAX) begin
        act_mul <= ACT_LEAVE;
      end else if (cov.cov >= TEXT_MIN) begin
        act_mul <= ACT_TEXT;
      end else begin
        act_mul <= ACT_BLEND;
      end
      bg_r <= MIX_W'(cov.bg.red)   * MIX_W'(inv_cov);
      bg_g <= MIX_W'(cov.bg.green) * MIX_W'(inv_cov);
      bg_b <= MIX_W'(cov.bg.blue)  * MIX_W'(inv_cov);
      fg_r <= MIX_W'(text.red)     * MIX_W'(cov.cov);
      fg_g <= MIX_W'(text.green)   * MIX_W'(cov.cov);
      fg_b <= MIX_W'(text.blue)    * MIX_W'(cov.cov);
    end
  end

  always_comb begin
    sum_r       = (MIX_W+1)'(bg_r) + (MIX_W+1)'(fg_r);
    sum_g       = (MIX_W+1)'(bg_g) + (MIX_W+1)'(fg_g);
    sum_b       = (MIX_W+1)'(bg_b) + (MIX_W+1)'(fg_b);
    blend.red   = sum_r[CH_W+16-1:16];
    blend.green = sum_g[CH_W+16-1:16];
    blend.blue  = sum_b[CH_W+16-1:16];
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      action <= act_mul;
      unique case (act_mul)
        ACT_TEXT:  color <= text;
        ACT_BLEND: color <= blend;
        default:   color <= '0;
      endcase
    end
  end

endmodule

// ----- sv/subpixel_glyph_pixel_blend.sv -----
// ----------------------------------------------------------------------------
// subpixel_glyph_pixel_blend
// Blends one destination pixel of a scaled, subpixel-placed 1-bit glyph.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one destination pixel per transaction: the
// column inside the glyph box, the two sampled glyph rows and the background
// colour. Output stream m_axis returns one transaction per input: the action
// (leave, write text colour, write blend) in tuser and the colour in tdata.
// Configuration registers (inverse scale, subpixel offsets, text colour) are
// written through cfg_wr_en/cfg_index/cfg_wr_data; the user must write them
// only while the stream is idle, as the block itself does not enforce it.
// Four register stages: index multiply, coverage sum, blend multiply, output.
// One pixel per cycle is accepted and delivered while the output is not stalled.
// Each stage holds its own valid bit and loads whenever it is empty or the
// next stage moves, so bubbles close up and a stalled output keeps accepting
// until all four stages are full; nothing is lost or repeated under stall.
// Synchronous reset clears the valid bits and loads the register reset values
// (scale 1.0, zero offsets, white text).
// ----------------------------------------------------------------------------
module subpixel_glyph_pixel_blend
  import sgpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // [11:0] local_x, [19:12] row, [27:20] prev_row,
  // [35:28] bg_red, [43:36] bg_green, [51:44] bg_blue, rest zero
  input  logic [55:0]           s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  output logic [23:0]           m_axis_tdata,
  // [1:0] action
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  cfg_t    cfg;
  logic    v1, v2, v3, v4;
  logic    rdy1, rdy2, rdy3, rdy4;
  rgb_t    bg_in;
  samp_t   samp;
  cov_t    cov;
  action_t action;
  rgb_t    color;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hscale <= INV_W'(4096);
      cfg.frac_x <= '0;
      cfg.frac_y <= '0;
      cfg.text   <= '1;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HSCALE:      cfg.hscale     <= cfg_wr_data[INV_W-1:0];
        REG_FRAC_X:      cfg.frac_x     <= cfg_wr_data[FRAC_W-1:0];
        REG_FRAC_Y:      cfg.frac_y     <= cfg_wr_data[FRAC_W-1:0];
        REG_TEXT_RED:    cfg.text.red   <= cfg_wr_data[CH_W-1:0];
        REG_TEXT_GREEN:  cfg.text.green <= cfg_wr_data[CH_W-1:0];
        REG_TEXT_BLUE:   cfg.text.blue  <= cfg_wr_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // per-stage load enables
  always_comb begin
    rdy4 = !v4 || m_axis_tready;
    rdy3 = !v3 || rdy4;
    rdy2 = !v2 || rdy3;
    rdy1 = !v1 || rdy2;
  end

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  assign bg_in.red   = s_axis_tdata[35:28];
  assign bg_in.green = s_axis_tdata[43:36];
  assign bg_in.blue  = s_axis_tdata[51:44];

  sgpb_index u_index (
    .clk    (clk),
    .en     (rdy1),
    .hscale (cfg.hscale),
    .x      (s_axis_tdata[X_BITS-1:0]),
    .row    (s_axis_tdata[19:12]),
    .prev   (s_axis_tdata[27:20]),
    .bg     (bg_in),
    .samp   (samp)
  );

  sgpb_coverage u_coverage (
    .clk  (clk),
    .en   (rdy2),
    .cfg  (cfg),
    .samp (samp),
    .cov  (cov)
  );

  sgpb_mix u_mix (
    .clk    (clk),
    .en_mul (rdy3),
    .en_out (rdy4),
    .text   (cfg.text),
    .cov    (cov),
    .action (action),
    .color  (color)
  );

  assign m_axis_tvalid = v4;
  assign m_axis_tuser  = action;
  assign m_axis_tdata  = {color.blue, color.green, color.red};

endmodule
